@@ rtl/core/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package spq_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int KEY_W        = 32;
	localparam int STATUS_W     = 2;
	localparam int OCC_W        = 5;

	// op codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture the incoming word
		logic exec;   // apply the captured op, fill result register
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
	} spq_stat_t;

endpackage

@@ rtl/core/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: streaming ports around controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
`timescale 1ns / 1ps
// Bounded minimum priority queue holding up to CAPACITY signed 32-bit keys in
// ascending order in a row of register cells. Each input word carries an op in
// s_tuser (insert or delete-min) and a key in s_tdata. An insert goes ahead of the
// first stored key that is greater or equal, so equal keys leave in reverse order
// of arrival. A delete returns the smallest key. Insert on a full queue (status 2)
// and delete on an empty queue (status 1) change nothing and return key zero.
// Every input word yields exactly one output word with the removed key, the
// status and the occupancy after the op (count modulo 32).
// Operation: a word is first captured, then executed in a step in which every cell
// shifts in parallel, on an insert after comparing against the key; its result is
// offered on m_tdata from the cycle after the execute cycle. A new word is taken only
// while the controller is idle and the result register is empty or is being read in
// that same cycle, so a result waiting on m_tready holds off s_tready, and no new word
// is taken during the execute cycle. No clearing pass after reset: only the count, state and valid flag reset.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic [0:0]  s_tuser,   // [0] op
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] removed_key, [36:32] occupancy, [39:37] zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	spq_cmd_t            cmd;
	spq_stat_t           stat;
	logic [KEY_W-1:0]    removed_key;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;

	// sequencer: capture word, then execute
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// key cells, count and result register
	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_op       (s_tuser[0]),
		.in_key      (s_tdata),
		.removed_key (removed_key),
		.status      (status),
		.occupancy   (occupancy)
	);

	assign m_tdata = {3'b000, occupancy, removed_key};
	assign m_tuser = status;

endmodule

@@ rtl/core/spq_ctrl.sv @@
// Controller for the sorted priority queue: two-state sequencer and result valid flag.
// Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_ctrl import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	// take a new word only when the result slot will be free by the exec cycle
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign cmd.load = s_tvalid && s_tready;
	assign cmd.exec = (state_q == ST_EXEC);
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result slot must be empty when a result is written
	a_exec_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !out_valid_q)
		else $error("result written over a pending result");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_tvalid)
		else $error("exec cycle did not raise m_tvalid");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue flagged full and empty at once");

endmodule

@@ rtl/core/spq_dp.sv @@
// Datapath for the sorted priority queue: row of key cells, count, input and result registers.
// Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_dp import spq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_cmd_t            cmd,
	output spq_stat_t           stat,
	input  logic                in_op,
	input  logic [KEY_W-1:0]    in_key,
	output logic [KEY_W-1:0]    removed_key,
	output logic [STATUS_W-1:0] status,
	output logic [OCC_W-1:0]    occupancy
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [KEY_W-1:0] keys_q [CAPACITY];
	logic signed [KEY_W-1:0] keys_nxt [CAPACITY];
	logic [CW-1:0]           count_q;
	logic                    op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CAPACITY-1:0]     gt;       // key_q lies above cell i (prefix of ones)
	logic                    full;
	logic                    empty;

	assign full       = (count_q == CW'(CAPACITY));
	assign empty      = (count_q == '0);
	assign stat.full  = full;
	assign stat.empty = empty;

	// each cell compares against its own entry; shift in from neighbor
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CW'(i) < count_q) && (key_q > keys_q[i]);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			keys_nxt[i] = keys_q[i];
			if (op_q == OP_INSERT) begin
				if (!gt[i]) begin
					if (i == 0) begin
						keys_nxt[i] = key_q;
					end else if (gt[i-1]) begin
						keys_nxt[i] = key_q;
					end else begin
						keys_nxt[i] = keys_q[i-1];
					end
				end
			end else if (i < CAPACITY - 1) begin
				keys_nxt[i] = keys_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_op;
			key_q <= in_key;
		end
		if (cmd.exec) begin
			if ((op_q == OP_INSERT && !full) || (op_q == OP_DELETE && !empty)) begin
				for (int i = 0; i < CAPACITY; i++) begin
					keys_q[i] <= keys_nxt[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == OP_INSERT && !full) begin
				count_q <= count_q + CW'(1);
			end else if (op_q == OP_DELETE && !empty) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// result register, written in the exec cycle
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			removed_key <= '0;
			status      <= STAT_OK;
			if (op_q == OP_INSERT) begin
				if (full) begin
					status    <= STAT_FULL;
					occupancy <= OCC_W'(count_q);
				end else begin
					occupancy <= OCC_W'(count_q + CW'(1));
				end
			end else begin
				if (empty) begin
					status    <= STAT_EMPTY;
					occupancy <= OCC_W'(count_q);
				end else begin
					removed_key <= keys_q[0];
					occupancy   <= OCC_W'(count_q - CW'(1));
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("key count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && op_q == OP_INSERT && !full) |=> count_q == $past(count_q) + CW'(1))
		else $error("accepted insert did not grow the count");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> !(keys_q[0] > keys_q[1]))
		else $error("two smallest keys out of order");

endmodule
